/* sv/ttc_pkg.sv */
// Package for the transcript text cleaner: sizes, character codes, helper functions and types.
`timescale 1ns / 1ps
`default_nettype none

package ttc_pkg;

    // Held word storage
    localparam int WORD_MAX = 32;
    localparam int IDX_W    = (WORD_MAX > 1) ? $clog2(WORD_MAX) : 1;
    localparam int CNT_W    = $clog2(WORD_MAX + 1);

    // Character codes
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_QUERY  = 8'h3F;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_HYPHEN = 8'h2D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CASE_OFS  = 8'h20;

    // Annotation skipping mode
    typedef enum logic [1:0] {
        SKIP_NONE  = 2'd0,
        SKIP_SLASH = 2'd1,
        SKIP_HASH  = 2'd2
    } skip_mode_t;

    // Main operation left for the sequencer after a byte is taken
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_PUSH  = 2'd1,
        OP_SPACE = 2'd2,
        OP_EOL   = 2'd3
    } op_kind_t;

    // Sequencer states
    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_STEP    = 6'b000010,
        ST_FL_SEP  = 6'b000100,
        ST_FL_RD   = 6'b001000,
        ST_FL_EMIT = 6'b010000,
        ST_TERM    = 6'b100000
    } state_t;

    // Tab, LF, VT, FF, CR and space
    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) ? (c - CASE_OFS) : c;
    endfunction

endpackage

`default_nettype wire

/* sv/transcript_text_cleaner_unit.sv */
// Transcript text cleaner: byte stream in, cleaned byte stream out, one line per terminator.
// A byte that releases the held word first emits the held separator, then reads and emits each
// held byte in turn (one store read, one emit).
// Throughput: one input transaction at a time; s_tready is high only while the sequencer idles.
// Reset: synchronous, active low; clears control state, the word store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module transcript_text_cleaner_unit
    import ttc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] text_byte
    input  wire logic       s_tlast,   // end_of_line
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] clean_byte
    output logic            m_tlast    // line_done
);

    state_t           state_reg, state_next;
    logic             pre_reg, pre_next;
    op_kind_t         kind_reg, kind_next;
    logic [7:0]       char_reg, char_next;
    skip_mode_t       skip_reg, skip_next;
    logic             hyph_reg, hyph_next;
    logic [7:0]       sep_char_reg, sep_char_next;
    logic             sep_valid_reg, sep_valid_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] fl_cnt_reg, fl_cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_data_reg, out_data_next;
    logic             out_last_reg, out_last_next;

    logic [7:0]       store [WORD_MAX];
    logic [7:0]       rd_data_reg;
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;

    logic             out_free;
    logic             flush_end;
    logic             word_full;
    logic [CNT_W-1:0] fl_cnt_inc;

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tlast    = out_last_reg;
    assign out_free   = !out_valid_reg || m_tready;
    assign word_full  = (count_reg == CNT_W'(WORD_MAX));
    assign fl_cnt_inc = fl_cnt_reg + CNT_W'(1);

    // Sequencer and store port control
    always_comb begin
        state_next     = state_reg;
        pre_next       = pre_reg;
        kind_next      = kind_reg;
        char_next      = char_reg;
        skip_next      = skip_reg;
        hyph_next      = hyph_reg;
        sep_char_next  = sep_char_reg;
        sep_valid_next = sep_valid_reg;
        count_next     = count_reg;
        fl_cnt_next    = fl_cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        we             = 1'b0;
        waddr          = count_reg[IDX_W-1:0];
        wdata          = char_reg;
        re             = 1'b0;
        raddr          = fl_cnt_reg[IDX_W-1:0];
        flush_end      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    pre_next  = 1'b0;
                    kind_next = OP_NONE;
                    char_next = s_tdata;
                    if (s_tlast) begin
                        // End of line: a waiting hyphen is kept, then flush and terminate
                        pre_next   = hyph_reg;
                        hyph_next  = 1'b0;
                        skip_next  = SKIP_NONE;
                        kind_next  = OP_EOL;
                        state_next = ST_STEP;
                    end else if (skip_reg != SKIP_NONE) begin
                        // Inside an annotation: watch for the closing delimiter only
                        if ((skip_reg == SKIP_SLASH && s_tdata == CH_SLASH) ||
                            (skip_reg == SKIP_HASH && s_tdata == CH_HASH)) begin
                            skip_next = SKIP_NONE;
                        end
                    end else begin
                        // Resolve a waiting hyphen: delete the held word or keep the hyphen
                        if (hyph_reg) begin
                            hyph_next = 1'b0;
                            if (is_ws(s_tdata)) begin
                                count_next     = '0;
                                sep_char_next  = CH_SPACE;
                                sep_valid_next = 1'b1;
                            end else begin
                                pre_next = 1'b1;
                            end
                        end
                        // Classify the byte
                        priority if (s_tdata == CH_COLON || s_tdata == CH_SEMI ||
                                     s_tdata == CH_QUERY || s_tdata == CH_BANG ||
                                     s_tdata == CH_LF) begin
                            kind_next = OP_NONE;
                        end else if (s_tdata == CH_COMMA || s_tdata == CH_BSLASH) begin
                            kind_next = OP_SPACE;
                            char_next = CH_SPACE;
                        end else if (s_tdata == CH_SLASH) begin
                            skip_next = SKIP_SLASH;
                        end else if (s_tdata == CH_HASH) begin
                            skip_next = SKIP_HASH;
                        end else if (s_tdata == CH_HYPHEN) begin
                            hyph_next = 1'b1;
                        end else if (is_ws(s_tdata)) begin
                            kind_next = OP_SPACE;
                        end else begin
                            kind_next = OP_PUSH;
                            char_next = to_upper(s_tdata);
                        end
                        if ((hyph_reg && !is_ws(s_tdata)) ||
                            s_tdata == CH_COMMA || s_tdata == CH_BSLASH ||
                            (s_tdata != CH_COLON && s_tdata != CH_SEMI &&
                             s_tdata != CH_QUERY && s_tdata != CH_BANG &&
                             s_tdata != CH_SLASH && s_tdata != CH_HASH &&
                             s_tdata != CH_HYPHEN)) begin
                            state_next = ST_STEP;
                        end
                    end
                end
            end

            ST_STEP: begin
                if (pre_reg) begin
                    // Append the kept hyphen, flushing first when the store is full
                    if (word_full) begin
                        state_next = ST_FL_SEP;
                    end else begin
                        we         = 1'b1;
                        wdata      = CH_HYPHEN;
                        count_next = count_reg + CNT_W'(1);
                        pre_next   = 1'b0;
                    end
                end else begin
                    unique case (kind_reg)
                        OP_NONE: begin
                            state_next = ST_IDLE;
                        end
                        OP_PUSH: begin
                            if (word_full) begin
                                state_next = ST_FL_SEP;
                            end else begin
                                we         = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                                kind_next  = OP_NONE;
                                state_next = ST_IDLE;
                            end
                        end
                        OP_SPACE, OP_EOL: begin
                            state_next = ST_FL_SEP;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_FL_SEP: begin
                // Emit the held separator, then walk the held word
                if (!sep_valid_reg || out_free) begin
                    if (sep_valid_reg) begin
                        out_valid_next = 1'b1;
                        out_data_next  = sep_char_reg;
                        out_last_next  = 1'b0;
                        sep_valid_next = 1'b0;
                    end
                    if (count_reg == '0) begin
                        flush_end = 1'b1;
                    end else begin
                        fl_cnt_next = '0;
                        state_next  = ST_FL_RD;
                    end
                end
            end

            ST_FL_RD: begin
                re         = 1'b1;
                state_next = ST_FL_EMIT;
            end

            ST_FL_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = rd_data_reg;
                    out_last_next  = 1'b0;
                    fl_cnt_next    = fl_cnt_inc;
                    if (fl_cnt_inc == count_reg) begin
                        flush_end = 1'b1;
                    end else begin
                        state_next = ST_FL_RD;
                    end
                end
            end

            ST_TERM: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Finish a flush and continue with the operation that asked for it
        if (flush_end) begin
            count_next = '0;
            if (pre_reg) begin
                state_next = ST_STEP;
            end else begin
                unique case (kind_reg)
                    OP_PUSH: begin
                        state_next = ST_STEP;
                    end
                    OP_SPACE: begin
                        sep_char_next  = char_reg;
                        sep_valid_next = 1'b1;
                        kind_next      = OP_NONE;
                        state_next     = ST_IDLE;
                    end
                    OP_EOL: begin
                        kind_next  = OP_NONE;
                        state_next = ST_TERM;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pre_reg       <= 1'b0;
            kind_reg      <= OP_NONE;
            skip_reg      <= SKIP_NONE;
            hyph_reg      <= 1'b0;
            sep_valid_reg <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pre_reg       <= pre_next;
            kind_reg      <= kind_next;
            skip_reg      <= skip_next;
            hyph_reg      <= hyph_next;
            sep_valid_reg <= sep_valid_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        char_reg     <= char_next;
        sep_char_reg <= sep_char_next;
        fl_cnt_reg   <= fl_cnt_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    // Word store: one write and one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            store[waddr] <= wdata;
        end
        if (re) begin
            rd_data_reg <= store[raddr];
        end
    end

endmodule

`default_nettype wire

/* sv/ttc_checker.sv */
// Port-level checker for the transcript text cleaner, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ttc_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       s_tlast,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast
);

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Terminator carries a zero byte
    a_term_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata == 8'h00)
        else $error("terminator with non-zero byte");

    // End of line always starts a flush, so the input side goes busy
    a_eol_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("ready after end-of-line transaction");

    // No result straight out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Ready after reset
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("not ready after reset");

endmodule

bind transcript_text_cleaner_unit ttc_checker u_ttc_checker (.*);

`default_nettype wire

/* dv/transcript_text_cleaner_unit_tb.sv */
// Testbench for the transcript text cleaner: directed and random lines checked against a predictor.
`timescale 1ns / 1ps

module transcript_text_cleaner_unit_tb;
    import ttc_pkg::*;

    localparam int         IDLE_LIMIT   = 4000;
    localparam int         RANDOM_ITEMS = 445;
    localparam int         DRAIN_CYCLES = 100;
    localparam logic [7:0] CH_VT        = 8'h0B;
    localparam logic [7:0] CH_FF        = 8'h0C;
    localparam logic [7:0] CH_DIGIT0    = 8'h30;

    // One cleaned character, or the line terminator
    typedef struct packed {
        logic [7:0] ch;
        logic       done;
    } clean_item_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] text_byte
    logic       s_tlast  = 1'b0;    // end_of_line
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] clean_byte
    logic       m_tlast;            // line_done

    // Cleaner state as the predictor sees it
    skip_mode_t  ann_mode  = SKIP_NONE;
    bit          dash_held = 1'b0;
    logic [7:0]  gap_char  = 8'h00;
    bit          gap_held  = 1'b0;
    logic [7:0]  held_word [WORD_MAX];
    int          held_len  = 0;

    clean_item_t pending_clean_q[$];
    int          fail_count = 0;
    int          idle_cycles = 0;
    int          rx_hold = 0;
    int          random_sent = 0;
    bit          calm = 1'b0;

    transcript_text_cleaner_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic bit is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic void release_held();
        if (gap_held)
            pending_clean_q.push_back('{ch: gap_char, done: 1'b0});
        for (int i = 0; i < held_len; i++)
            pending_clean_q.push_back('{ch: held_word[i], done: 1'b0});
        gap_held = 1'b0;
        held_len = 0;
    endfunction

    // Flush early when the word store is already full
    function automatic void hold_char(input logic [7:0] c);
        if (held_len >= WORD_MAX)
            release_held();
        held_word[held_len] = c;
        held_len++;
    endfunction

    function automatic void open_gap(input logic [7:0] c);
        release_held();
        gap_char = c;
        gap_held = 1'b1;
    endfunction

    function automatic void clean_text_byte(input logic [7:0] c, input logic eol);
        if (eol) begin
            if (dash_held)
                hold_char(CH_HYPHEN);
            dash_held = 1'b0;
            ann_mode  = SKIP_NONE;
            release_held();
            pending_clean_q.push_back('{ch: 8'h00, done: 1'b1});
            return;
        end
        // Inside an annotation only the matching delimiter matters
        if (ann_mode != SKIP_NONE) begin
            if ((ann_mode == SKIP_SLASH && c == CH_SLASH) ||
                (ann_mode == SKIP_HASH && c == CH_HASH))
                ann_mode = SKIP_NONE;
            return;
        end
        // Resolve a waiting hyphen: whitespace deletes the held word
        if (dash_held) begin
            dash_held = 1'b0;
            if (is_blank(c)) begin
                held_len = 0;
                gap_char = CH_SPACE;
                gap_held = 1'b1;
            end else begin
                hold_char(CH_HYPHEN);
            end
        end
        case (c)
            CH_COLON, CH_SEMI, CH_QUERY, CH_BANG, CH_LF: ;
            CH_COMMA, CH_BSLASH: open_gap(CH_SPACE);
            CH_SLASH:  ann_mode = SKIP_SLASH;
            CH_HASH:   ann_mode = SKIP_HASH;
            CH_HYPHEN: dash_held = 1'b1;
            default: begin
                if (is_blank(c))
                    open_gap(c);
                else if (c >= CH_LOW_A && c <= CH_LOW_Z)
                    hold_char(c - CASE_OFS);
                else
                    hold_char(c);
            end
        endcase
    endfunction

    // ---------------------------------------------------------------- handshakes

    // Mostly short gaps, a few long ones, none while calm
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    task automatic send_text(input logic [7:0] c, input logic eol);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eol;
        do @(posedge aclk); while (!s_tready);
        clean_text_byte(c, eol);
    endtask

    task automatic send_word(input string w);
        for (int i = 0; i < w.len(); i++)
            send_text(w[i], 1'b0);
    endtask

    task automatic end_line();
        send_text(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Random receiver stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b1;
        end else if (rx_hold > 0) begin
            rx_hold--;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            rx_hold = idle_len();
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        clean_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_clean_q.size() == 0) begin
                $error("unexpected result: clean_byte 0x%02h line_done %0b", m_tdata, m_tlast);
                fail_count++;
            end else begin
                want = pending_clean_q.pop_front();
                if (m_tdata !== want.ch) begin
                    $error("clean_byte: expected 0x%02h, got 0x%02h", want.ch, m_tdata);
                    fail_count++;
                end
                if (m_tlast !== want.done) begin
                    $error("line_done: expected %0b, got %0b", want.done, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------- random content

    function automatic logic [7:0] word_char();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12)
            return CH_LOW_A + 8'($urandom_range(0, 25));
        if (r < 15)
            return CH_LOW_A - CASE_OFS + 8'($urandom_range(0, 25));
        if (r < 17)
            return CH_DIGIT0 + 8'($urandom_range(0, 9));
        if (r < 19)
            return 8'($urandom_range(128, 255));
        return 8'h00;
    endfunction

    function automatic int word_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(WORD_MAX - 2, WORD_MAX + 9);
        return $urandom_range(1, 7);
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 5))
            0:       return CH_TAB;
            1:       return CH_LF;
            2:       return CH_VT;
            3:       return CH_FF;
            4:       return CH_CR;
            default: return CH_SPACE;
        endcase
    endfunction

    function automatic logic [7:0] sep_char();
        case ($urandom_range(0, 3))
            0:       return CH_COMMA;
            1:       return CH_BSLASH;
            default: return blank_char();
        endcase
    endfunction

    function automatic logic [7:0] punct_char();
        case ($urandom_range(0, 5))
            0:       return CH_COLON;
            1:       return CH_SEMI;
            2:       return CH_QUERY;
            3:       return CH_BANG;
            4:       return CH_COMMA;
            default: return CH_BSLASH;
        endcase
    endfunction

    // ---------------------------------------------------------------- tests

    // Case folding, byte extremes, dropped and spaced punctuation
    task automatic test_char_classes();
        send_word("az");
        send_text(8'h00, 1'b0);
        send_text(8'hFF, 1'b0);
        send_text(CH_COLON, 1'b0);
        send_text(CH_SEMI, 1'b0);
        send_text(CH_QUERY, 1'b0);
        send_text(CH_BANG, 1'b0);
        send_text(CH_LF, 1'b0);
        send_text(CH_COMMA, 1'b0);
        send_text(CH_BSLASH, 1'b0);
        end_line();
    endtask

    // Closed slash annotation with a byte straight after, unclosed hash annotation
    task automatic test_annotations();
        send_text(CH_SLASH, 1'b0);
        send_word("x");
        send_text(CH_SLASH, 1'b0);
        send_word("k");
        send_text(CH_HASH, 1'b0);
        send_word("y");
        end_line();
    endtask

    // Hyphen kept inside a word, deletion without separator, hyphen before end of line
    task automatic test_hyphen_rules();
        send_word("a");
        send_text(CH_HYPHEN, 1'b0);
        send_word("b");
        send_text(CH_HYPHEN, 1'b0);
        send_text(CH_SPACE, 1'b0);
        send_word("c");
        send_text(CH_HYPHEN, 1'b0);
        end_line();
    endtask

    // Mostly well-formed lines with random words, plus noise and broken annotations
    task automatic test_random_lines();
        logic [7:0] line_q[$];
        logic [7:0] closer;
        int         kind;
        int         len;
        while (random_sent < RANDOM_ITEMS) begin
            line_q.delete();
            calm = ($urandom_range(0, 4) == 0);
            for (int t = $urandom_range(1, 6); t > 0; t--) begin
                kind = $urandom_range(0, 99);
                if (kind < 40) begin
                    len = word_len();
                    repeat (len) line_q.push_back(word_char());
                    line_q.push_back(sep_char());
                end else if (kind < 55) begin
                    len = word_len();
                    repeat (len) line_q.push_back(word_char());
                    line_q.push_back(CH_HYPHEN);
                    line_q.push_back(blank_char());
                end else if (kind < 63) begin
                    repeat ($urandom_range(1, 5)) line_q.push_back(word_char());
                    line_q.push_back(CH_HYPHEN);
                    repeat ($urandom_range(1, 5)) line_q.push_back(word_char());
                    line_q.push_back(sep_char());
                end else if (kind < 71) begin
                    closer = $urandom_range(0, 1) ? CH_SLASH : CH_HASH;
                    line_q.push_back(closer);
                    repeat ($urandom_range(0, 5)) line_q.push_back(word_char());
                    line_q.push_back(closer);
                end else if (kind < 79) begin
                    line_q.push_back(punct_char());
                end else if (kind < 87) begin
                    line_q.push_back(8'($urandom_range(0, 255)));
                end else if (kind < 93) begin
                    repeat ($urandom_range(1, 4)) line_q.push_back(word_char());
                    line_q.push_back(CH_HYPHEN);
                end else begin
                    // Unclosed annotation runs to the end of the line
                    line_q.push_back($urandom_range(0, 1) ? CH_SLASH : CH_HASH);
                    repeat ($urandom_range(0, 4)) line_q.push_back(word_char());
                    break;
                end
            end
            foreach (line_q[i])
                send_text(line_q[i], 1'b0);
            end_line();
            random_sent += line_q.size() + 1;
        end
        calm = 1'b0;
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        test_char_classes();
        test_annotations();
        test_hyphen_rules();
        test_random_lines();
        s_tvalid <= 1'b0;

        // Drain outstanding results, then allow for trailing activity
        while (pending_clean_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && pending_clean_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
